/* hw/rtl/bpc_pkg.sv */
// ============================================================================
// Barometric pressure compensation: shared package
// Calibration record, stage payload types, register indexes and constants.
// ============================================================================
`default_nettype none

package bpc_pkg;

    // Divider geometry: one quotient bit per stage.
    localparam int DIV_W    = 32;
    localparam int DIV_STEPS = DIV_W;
    localparam int SIDE_W   = 64;

    // Configuration register indexes.
    localparam logic [2:0] REG_CAL_A = 3'd0;
    localparam logic [2:0] REG_CAL_B = 3'd1;
    localparam logic [2:0] REG_CAL_C = 3'd2;
    localparam logic [2:0] REG_CAL_D = 3'd3;
    localparam logic [2:0] REG_OSS   = 3'd4;

    // Compensation constants.
    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic [31:0]        B4_OFFSET = 32'd32768;
    localparam logic [15:0]        B7_SCALE  = 16'd50000;
    localparam logic signed [31:0] P_COEF_A  = 32'sd3038;
    localparam logic signed [31:0] P_COEF_B  = -32'sd7357;
    localparam logic signed [31:0] P_COEF_C  = 32'sd3791;

    // Unpacked calibration words.
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } t_cal;

    // Item handed from the temperature section to the pressure section.
    typedef struct packed {
        logic signed [31:0] b6;
        logic [18:0]        up;
        logic               err;
    } t_temp_res;

endpackage

`default_nettype wire

/* hw/rtl/barometric_pressure_compensation_top.sv */
// ============================================================================
// Barometric pressure compensation top level
// Stream in raw temperature and pressure, stream out pressure in pascals.
// ============================================================================
// The block accepts one item per clock while the output is not stalled and
// returns one result per item, in order, through 77 register stages. The
// depth is set by two 32-stage pipelined dividers (one quotient bit per
// stage) plus the multiply stages around them. The whole pipeline advances
// whenever the output register is empty or being taken, so a stall on the
// output holds every item in place. Calibration and oversampling are
// written through the configuration port; the user must write them only
// while no item is in flight, which the block itself does not enforce. A
// zero divisor gives pressure 0 with the error flag set in tuser.
`default_nettype none

module barometric_pressure_compensation_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // raw_temperature [15:0], raw_pressure [34:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // pressure_pa [31:0]
    output logic             m_axis_tuser   // divide_error [0]
);
    import bpc_pkg::*;

    logic [47:0]        r_cal_a;
    logic [47:0]        r_cal_b;
    logic [31:0]        r_cal_c;
    logic [31:0]        r_cal_d;
    logic [1:0]         r_oss;
    t_cal               w_cal;
    logic               w_en;
    logic               w_tv;
    t_temp_res          w_tres;
    logic               w_ov;
    logic signed [31:0] w_p;
    logic               w_err;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_cal_d <= '0;
            r_oss   <= 2'd3;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_CAL_A: r_cal_a <= i_cfg_data;
                REG_CAL_B: r_cal_b <= i_cfg_data;
                REG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                REG_CAL_D: r_cal_d <= i_cfg_data[31:0];
                REG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Unpack calibration words.
    assign w_cal.ac1 = r_cal_a[47:32];
    assign w_cal.ac2 = r_cal_a[31:16];
    assign w_cal.ac3 = r_cal_a[15:0];
    assign w_cal.ac4 = r_cal_b[47:32];
    assign w_cal.ac5 = r_cal_b[31:16];
    assign w_cal.ac6 = r_cal_b[15:0];
    assign w_cal.b1  = r_cal_c[31:16];
    assign w_cal.b2  = r_cal_c[15:0];
    assign w_cal.mc  = r_cal_d[31:16];
    assign w_cal.md  = r_cal_d[15:0];
    assign w_cal.oss = r_oss;

    // Pipeline advances when the output register is free or being taken.
    assign w_en          = !w_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cal   (w_cal),
        .i_valid (s_axis_tvalid),
        .i_ut    (s_axis_tdata[15:0]),
        .i_up    (s_axis_tdata[34:16]),
        .o_valid (w_tv),
        .o_res   (w_tres)
    );

    bpc_press u_press (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_cal      (w_cal),
        .i_valid    (w_tv),
        .i_res      (w_tres),
        .o_valid    (w_ov),
        .o_pressure (w_p),
        .o_err      (w_err)
    );

    assign m_axis_tvalid = w_ov;
    assign m_axis_tdata  = w_p;
    assign m_axis_tuser  = w_err;

endmodule

`default_nettype wire

/* hw/rtl/bpc_div.sv */
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a sideband carried
// alongside the operands so that each item keeps its own context.
// ============================================================================
`default_nettype none

module bpc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [bpc_pkg::DIV_W-1:0]    i_num,
    input  wire logic [bpc_pkg::DIV_W-1:0]    i_den,
    input  wire logic [bpc_pkg::SIDE_W-1:0]   i_side,
    output logic                              o_valid,
    output logic [bpc_pkg::DIV_W-1:0]         o_quot,
    output logic [bpc_pkg::SIDE_W-1:0]        o_side
);
    import bpc_pkg::*;

    logic [DIV_W-1:0]  r_rem  [DIV_STEPS];
    logic [DIV_W-1:0]  r_nq   [DIV_STEPS];
    logic [DIV_W-1:0]  r_den  [DIV_STEPS];
    logic [SIDE_W-1:0] r_side [DIV_STEPS];
    logic              r_v    [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [DIV_W-1:0]  a_rem;
        logic [DIV_W-1:0]  a_nq;
        logic [DIV_W-1:0]  a_den;
        logic [SIDE_W-1:0] a_side;
        logic              a_v;
        logic [DIV_W:0]    w_try;
        logic [DIV_W:0]    w_diff;
        logic              ge;

        // Stage operands come from the ports or from the previous stage.
        if (g == 0) begin : g_first
            assign a_rem  = '0;
            assign a_nq   = i_num;
            assign a_den  = i_den;
            assign a_side = i_side;
            assign a_v    = i_valid;
        end else begin : g_next
            assign a_rem  = r_rem[g-1];
            assign a_nq   = r_nq[g-1];
            assign a_den  = r_den[g-1];
            assign a_side = r_side[g-1];
            assign a_v    = r_v[g-1];
        end

        // Shift in the next dividend bit and try the subtraction.
        assign w_try  = {a_rem, a_nq[DIV_W-1]};
        assign w_diff = w_try - {1'b0, a_den};
        assign ge     = (w_try >= {1'b0, a_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? w_diff[DIV_W-1:0] : w_try[DIV_W-1:0];
                r_nq[g]   <= {a_nq[DIV_W-2:0], ge};
                r_den[g]  <= a_den;
                r_side[g] <= a_side;
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quot  = r_nq[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

`default_nettype wire

/* hw/rtl/bpc_temp.sv */
// ============================================================================
// Temperature section
// Computes x1 and the first division, then b6, for each item.
// ============================================================================
`default_nettype none

module bpc_temp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire bpc_pkg::t_cal      i_cal,
    input  wire logic               i_valid,
    input  wire logic [15:0]        i_ut,
    input  wire logic [18:0]        i_up,
    output logic                    o_valid,
    output bpc_pkg::t_temp_res      o_res
);
    import bpc_pkg::*;

    // Stage 1: signed temperature difference.
    logic               r_v1;
    logic signed [16:0] r_d1;
    logic [18:0]        r_up1;

    // Stage 2: product with AC5.
    logic               r_v2;
    logic signed [31:0] r_p2;
    logic [18:0]        r_up2;
    logic signed [33:0] w_p2;

    // Stage 3: x1, divisor and operand magnitudes.
    logic               r_v3;
    logic signed [31:0] r_x1_3;
    logic [31:0]        r_nabs3;
    logic [31:0]        r_dabs3;
    logic               r_neg3;
    logic               r_err3;
    logic [18:0]        r_up3;
    logic signed [31:0] w_x1;
    logic signed [31:0] w_den;
    logic signed [31:0] w_num;

    // Divider outputs.
    logic               w_dv;
    logic [31:0]        w_q;
    logic [SIDE_W-1:0]  w_side_in;
    logic [SIDE_W-1:0]  w_side_out;
    logic signed [31:0] w_x1_d;
    logic signed [31:0] w_x2;
    logic signed [31:0] w_b6;

    // Output stage.
    logic               r_vo;
    t_temp_res          r_res;

    assign w_p2  = r_d1 * $signed({1'b0, i_cal.ac5});
    assign w_x1  = r_p2 >>> 15;
    assign w_den = w_x1 + 32'(i_cal.md);
    assign w_num = {{5{i_cal.mc[15]}}, i_cal.mc, 11'b0};

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= w_dv;
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1    <= $signed({1'b0, i_ut}) - $signed({1'b0, i_cal.ac6});
            r_up1   <= i_up;
            r_p2    <= w_p2[31:0];
            r_up2   <= r_up1;
            r_x1_3  <= w_x1;
            r_nabs3 <= w_num[31] ? 32'(-w_num) : w_num;
            r_dabs3 <= w_den[31] ? 32'(-w_den) : w_den;
            r_neg3  <= w_num[31] ^ w_den[31];
            r_err3  <= (w_den == 32'sd0);
            r_up3   <= r_up2;
            r_res.b6  <= w_b6;
            r_res.up  <= w_side_out[20:2];
            r_res.err <= w_side_out[0];
        end
    end

    // The divider carries x1, the raw pressure, the sign and the error flag.
    assign w_side_in = SIDE_W'({r_x1_3, r_up3, r_neg3, r_err3});

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v3),
        .i_num   (r_nabs3),
        .i_den   (r_dabs3),
        .i_side  (w_side_in),
        .o_valid (w_dv),
        .o_quot  (w_q),
        .o_side  (w_side_out)
    );

    // Restore the quotient sign and form b6.
    assign w_x1_d = w_side_out[52:21];
    assign w_x2   = w_side_out[1] ? 32'(-$signed(w_q)) : $signed(w_q);
    assign w_b6   = w_x1_d + w_x2 - B6_OFFSET;

    assign o_valid = r_vo;
    assign o_res   = r_res;

endmodule

`default_nettype wire

/* hw/rtl/bpc_press.sv */
// ============================================================================
// Pressure section
// Computes b3, b4 and b7, the second division and the final correction.
// ============================================================================
`default_nettype none

module bpc_press (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire bpc_pkg::t_cal      i_cal,
    input  wire logic               i_valid,
    input  wire bpc_pkg::t_temp_res i_res,
    output logic                    o_valid,
    output logic signed [31:0]      o_pressure,
    output logic                    o_err
);
    import bpc_pkg::*;

    logic               r_v [6];
    logic [18:0]        r_up [6];
    logic               r_err [6];

    // Stage 1 products of b6.
    logic signed [63:0] w_sq1;
    logic signed [47:0] w_m2;
    logic signed [47:0] w_m3;
    logic signed [31:0] r_sqp1;
    logic signed [31:0] r_m2_1;
    logic signed [31:0] r_m3_1;

    // Stage 2 scaled terms.
    logic signed [31:0] r_sq2;
    logic signed [31:0] r_x2a2;
    logic signed [31:0] r_x1c2;

    // Stage 3 products with B1 and B2.
    logic signed [47:0] w_b2sq;
    logic signed [47:0] w_b1sq;
    logic signed [31:0] r_b2sq3;
    logic signed [31:0] r_b1sq3;
    logic signed [31:0] r_x2a3;
    logic signed [31:0] r_x1c3;

    // Stage 4 sums.
    logic signed [31:0] w_sa;
    logic signed [31:0] w_pbs;
    logic signed [31:0] r_sa4;
    logic signed [31:0] r_pb4;

    // Stage 5 b3 and b4 product.
    logic signed [31:0] w_sh;
    logic signed [31:0] w_b3r;
    logic [31:0]        w_pbo;
    logic [47:0]        w_b4p;
    logic signed [31:0] r_b3_5;
    logic [31:0]        r_b4p5;

    // Stage 6 b4 and b7.
    logic [16:0]        w_b4;
    logic [31:0]        w_diff;
    logic [15:0]        w_scale;
    logic [47:0]        w_b7;
    logic [16:0]        r_b4_6;
    logic [31:0]        r_b7_6;

    // Divider.
    logic [31:0]        w_num;
    logic [SIDE_W-1:0]  w_side_in;
    logic [SIDE_W-1:0]  w_side_out;
    logic               w_dv;
    logic [31:0]        w_q;
    logic signed [31:0] w_pu;

    // Correction stages.
    logic signed [31:0] w_ps;
    logic signed [63:0] w_s2;
    logic signed [63:0] w_m7;
    logic               r_v8;
    logic               r_err8;
    logic signed [31:0] r_p8;
    logic signed [31:0] r_s2_8;
    logic signed [31:0] r_m7_8;
    logic signed [63:0] w_m9;
    logic               r_v9;
    logic               r_err9;
    logic signed [31:0] r_p9;
    logic signed [31:0] r_x1_9;
    logic signed [31:0] r_x2_9;
    logic signed [31:0] w_sum;
    logic signed [31:0] w_p;
    logic               r_vo;
    logic               r_erro;
    logic signed [31:0] r_po;

    assign w_sq1  = i_res.b6 * i_res.b6;
    assign w_m2   = i_cal.ac2 * i_res.b6;
    assign w_m3   = i_cal.ac3 * i_res.b6;
    assign w_b2sq = i_cal.b2 * r_sq2;
    assign w_b1sq = i_cal.b1 * r_sq2;
    assign w_sa   = (32'(i_cal.ac1) <<< 2) + (r_b2sq3 >>> 11) + r_x2a3;
    assign w_pbs  = r_x1c3 + (r_b1sq3 >>> 16) + 32'sd2;
    assign w_sh   = r_sa4 << i_cal.oss;
    assign w_b3r  = w_sh + 32'sd2;
    assign w_pbo  = r_pb4 + B4_OFFSET;
    assign w_b4p  = i_cal.ac4 * w_pbo;
    assign w_b4   = r_b4p5[31:15];
    assign w_diff = {13'b0, r_up[4]} - r_b3_5;
    assign w_scale = B7_SCALE >> i_cal.oss;
    assign w_b7   = w_diff * w_scale;

    // Valid chain around the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_v[k] <= 1'b0;
            end
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 6; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_v8 <= w_dv;
            r_v9 <= r_v8;
            r_vo <= r_v9;
        end
    end

    // Payload stages ahead of the divider.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_up[0]  <= i_res.up;
            r_err[0] <= i_res.err;
            for (int k = 1; k < 5; k++) begin
                r_up[k]  <= r_up[k-1];
                r_err[k] <= r_err[k-1];
            end
            r_up[5]  <= r_up[4];
            r_err[5] <= r_err[4] | (w_b4 == 17'd0);
            r_sqp1  <= w_sq1[31:0];
            r_m2_1  <= w_m2[31:0];
            r_m3_1  <= w_m3[31:0];
            r_sq2   <= r_sqp1 >>> 12;
            r_x2a2  <= r_m2_1 >>> 11;
            r_x1c2  <= r_m3_1 >>> 13;
            r_b2sq3 <= w_b2sq[31:0];
            r_b1sq3 <= w_b1sq[31:0];
            r_x2a3  <= r_x2a2;
            r_x1c3  <= r_x1c2;
            r_sa4   <= w_sa;
            r_pb4   <= w_pbs >>> 2;
            r_b3_5  <= w_b3r >>> 2;
            r_b4p5  <= w_b4p[31:0];
            r_b4_6  <= w_b4;
            r_b7_6  <= w_b7[31:0];
        end
    end

    // Large b7 is divided first and doubled after, small b7 doubled first.
    assign w_num     = r_b7_6[31] ? r_b7_6 : {r_b7_6[30:0], 1'b0};
    assign w_side_in = SIDE_W'({r_b7_6[31], r_err[5]});

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v[5]),
        .i_num   (w_num),
        .i_den   ({15'b0, r_b4_6}),
        .i_side  (w_side_in),
        .o_valid (w_dv),
        .o_quot  (w_q),
        .o_side  (w_side_out)
    );

    assign w_pu = w_side_out[1] ? $signed({w_q[30:0], 1'b0}) : $signed(w_q);
    assign w_ps = w_pu >>> 8;
    assign w_s2 = w_ps * w_ps;
    assign w_m7 = P_COEF_B * w_pu;
    assign w_m9 = r_s2_8 * P_COEF_A;
    assign w_sum = r_x1_9 + r_x2_9 + P_COEF_C;
    assign w_p   = r_p9 + (w_sum >>> 4);

    // Final correction stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p8   <= w_pu;
            r_s2_8 <= w_s2[31:0];
            r_m7_8 <= w_m7[31:0];
            r_err8 <= w_side_out[0];
            r_p9   <= r_p8;
            r_x1_9 <= $signed(w_m9[31:0]) >>> 16;
            r_x2_9 <= r_m7_8 >>> 16;
            r_err9 <= r_err8;
            r_po   <= r_err9 ? 32'sd0 : w_p;
            r_erro <= r_err9;
        end
    end

    assign o_valid    = r_vo;
    assign o_pressure = r_po;
    assign o_err      = r_erro;

endmodule

`default_nettype wire

/* sim/bpc_checker.sv */
// ============================================================================
// Pressure compensation checker
// Watches the input and output streams and the configuration port, predicts
// the compensated pressure of every accepted item, and compares in order.
// ============================================================================
`timescale 1ns / 100ps

module bpc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [39:0] i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_out_data,
    input  wire logic        i_out_err,
    output int               o_fail_count,
    output int               o_pending
);
    import bpc_pkg::*;

    typedef struct packed {
        logic [31:0] pressure;
        logic        err;
    } t_pressure_res;

    logic [47:0] cal_a, cal_b;
    logic [31:0] cal_c, cal_d;
    logic [1:0]  oss;
    t_pressure_res pressure_q[$];

    // Integer datasheet algorithm with 32-bit wrapping intermediates.
    function automatic t_pressure_res compensate(logic [15:0] ut, logic [18:0] up);
        logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
        logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, p, den;
        logic [31:0] b4, b7, pu;
        t_pressure_res r;
        ac1 = 32'(signed'(cal_a[47:32]));
        ac2 = 32'(signed'(cal_a[31:16]));
        ac3 = 32'(signed'(cal_a[15:0]));
        ac4 = {16'd0, cal_b[47:32]};
        ac5 = {16'd0, cal_b[31:16]};
        ac6 = {16'd0, cal_b[15:0]};
        b1  = 32'(signed'(cal_c[31:16]));
        b2  = 32'(signed'(cal_c[15:0]));
        mc  = 32'(signed'(cal_d[31:16]));
        md  = 32'(signed'(cal_d[15:0]));
        r = '0;
        x1 = (($signed({16'd0, ut}) - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) begin
            r.err = 1'b1;
            return r;
        end
        // Truncating division; the only overflow case wraps like 64-bit cast.
        x2 = 32'(64'(signed'(mc * 2048)) / 64'(den));
        b5 = x1 + x2;
        b6 = b5 - B6_OFFSET;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = (((ac1 * 4 + x3) << oss) + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = ((x1 + x2) + 2) >>> 2;
        b4 = (32'(ac4) * (32'(x3) + B4_OFFSET)) >> 15;
        if (b4 == 0) begin
            r.err = 1'b1;
            return r;
        end
        b7 = ({13'd0, up} - 32'(b3)) * (32'(B7_SCALE) >> oss);
        if (b7 < 32'h8000_0000) pu = (b7 << 1) / b4;
        else pu = (b7 / b4) << 1;
        p = signed'(pu);
        x1 = (p >>> 8) * (p >>> 8);
        x1 = (x1 * P_COEF_A) >>> 16;
        x2 = (P_COEF_B * p) >>> 16;
        p = p + ((x1 + x2 + P_COEF_C) >>> 4);
        r.pressure = p;
        return r;
    endfunction

    assign o_pending = pressure_q.size();

    always @(posedge i_clk) begin
        t_pressure_res want;
        if (!i_rst_n) begin
            cal_a <= '0;
            cal_b <= '0;
            cal_c <= '0;
            cal_d <= '0;
            oss   <= 2'd3;
            o_fail_count <= 0;
        end else begin
            // Register writes.
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_CAL_A: cal_a <= i_cfg_data;
                    REG_CAL_B: cal_b <= i_cfg_data;
                    REG_CAL_C: cal_c <= i_cfg_data[31:0];
                    REG_CAL_D: cal_d <= i_cfg_data[31:0];
                    REG_OSS:   oss   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            // Predict each accepted item.
            if (i_in_valid && i_in_ready)
                pressure_q.push_back(compensate(i_in_data[15:0], i_in_data[34:16]));
            // Compare each accepted result with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (pressure_q.size() == 0) begin
                    $display("%0t: unexpected result pressure=%h err=%b",
                             $time, i_out_data, i_out_err);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pressure_q.pop_front();
                    if (want.pressure !== i_out_data || want.err !== i_out_err) begin
                        $display("%0t: expected pressure=%h err=%b, got pressure=%h err=%b",
                                 $time, want.pressure, want.err, i_out_data, i_out_err);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* sim/tb_top.sv */
// ============================================================================
// Pressure compensation testbench
// Writes calibration sets between phases, streams directed and random raw
// samples with random idling on both sides, and reports the checker verdict.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
    import bpc_pkg::*;

    localparam int LATENCY = 77;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // raw_temperature [15:0], raw_pressure [34:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // pressure_pa [31:0]
    logic        m_axis_tuser;   // divide_error [0]
    int          fail_count;
    int          pending;
    bit          no_idle;

    barometric_pressure_compensation_top i_dut (.*);

    bpc_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_err(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL barometric_pressure_compensation_top");
        $finish;
    end

    // Receiver stalls in random bursts.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (no_idle || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    // One register write, after which the write enable is dropped again.
    task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until the block has drained, then let the pipeline settle.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Send one sample, with an occasional burst of idling before it.
    task automatic send_sample(logic [15:0] ut, logic [18:0] up);
        int n;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, up, ut};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Calibration close to a real sensor, with random spread.
    task automatic cal_typical(logic [1:0] o);
        cfg_write(REG_CAL_A, {16'd408 + 16'($urandom_range(0, 400)),
                              -16'sd72 - 16'($urandom_range(0, 50)),
                              -16'sd14383 + 16'($urandom_range(0, 2000))});
        cfg_write(REG_CAL_B, {16'd32741 + 16'($urandom_range(0, 2000)),
                              16'd32757 - 16'($urandom_range(0, 8000)),
                              16'd23153 + 16'($urandom_range(0, 2000))});
        cfg_write(REG_CAL_C, {16'd6190 + 16'($urandom_range(0, 300)),
                              16'd4 + 16'($urandom_range(0, 40))});
        cfg_write(REG_CAL_D, {-16'sd8711 + 16'($urandom_range(0, 1000)),
                              16'd2868 + 16'($urandom_range(0, 200))});
        cfg_write(REG_OSS, {46'd0, o});
    endtask

    task automatic cal_random();
        cfg_write(REG_CAL_A, 48'({$urandom, $urandom}));
        cfg_write(REG_CAL_B, 48'({$urandom, $urandom}));
        cfg_write(REG_CAL_C, {16'($urandom), $urandom});
        cfg_write(REG_CAL_D, {16'($urandom), $urandom});
        cfg_write(REG_OSS, 48'({$urandom, $urandom}));
        // Unused index must be ignored.
        cfg_write(3'd5 + 3'($urandom_range(0, 2)), 48'({$urandom, $urandom}));
    endtask

    task automatic random_samples(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) != 0)
                send_sample(16'd24000 + 16'($urandom_range(0, 12000)),
                            19'd150000 + 19'($urandom_range(0, 250000)));
            else
                send_sample(16'($urandom), 19'($urandom));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = REG_CAL_A;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: every divisor is zero.
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        s_axis_tvalid <= 1'b0;
        drain();

        // Datasheet example and extremes of both fields.
        cfg_write(REG_CAL_A, {16'd408, -16'sd72, -16'sd14383});
        cfg_write(REG_CAL_B, {16'd32741, 16'd32757, 16'd23153});
        cfg_write(REG_CAL_C, {16'd6190, 16'd4});
        cfg_write(REG_CAL_D, {-16'sd8711, 16'd2868});
        cfg_write(REG_OSS, 48'd0);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd23153, 19'h40000);
        send_sample(16'h8000, 19'd1);
        s_axis_tvalid <= 1'b0;
        drain();

        // Temperature divisor zero: x1 is zero when ut equals AC6, and MD is zero.
        cfg_write(REG_CAL_D, {-16'sd8711, 16'd0});
        send_sample(16'd23153, 19'd300000);
        s_axis_tvalid <= 1'b0;
        drain();
        // Pressure divisor zero through AC4.
        cfg_write(REG_CAL_B, 48'd0);
        cfg_write(REG_CAL_D, {-16'sd8711, 16'd2868});
        drain();
        send_sample(16'd27898, 19'd300000);
        s_axis_tvalid <= 1'b0;
        drain();

        // Extreme calibration words at each oversampling setting.
        cfg_write(REG_CAL_A, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_CAL_B, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_CAL_C, 48'h8000_7FFF);
        cfg_write(REG_CAL_D, 48'h7FFF_8000);
        for (int o = 0; o < 4; o++) begin
            cfg_write(REG_OSS, 48'(o));
            send_sample(16'hFFFF, 19'h7FFFF);
            send_sample(16'd0, 19'd0);
            s_axis_tvalid <= 1'b0;
            drain();
        end

        // Random phases: typical and fully random calibration.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2) cal_random();
            else cal_typical(2'(ph));
            if (ph == 7) no_idle = 1'b1;
            random_samples(210);
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS barometric_pressure_compensation_top");
        end else begin
            $display("FAIL barometric_pressure_compensation_top");
        end
        $finish;
    end
endmodule
